// File: rtl/core/hcb_pkg.sv
`timescale 1ns / 1ps
package hcb_pkg;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [23:0] weight;
    logic        final_symbol;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  code_symbol;
    logic [5:0]  code_length;
    logic [62:0] code_bits;
    logic        dropped;
    logic        last_code;
  } out_item_t;

  localparam int WEIGHT_W = 30;

endpackage

// File: rtl/core/hcb_ram.sv
`timescale 1ns / 1ps
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/huffman_code_builder.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload                              Handshake
// in_      input      in_item_t (symbol, weight, final)    in_valid / in_ready
// out_     output     out_item_t (one code per leaf)       out_valid / out_ready
//
// Symbols load at one item per cycle, each that fits a single write to the symbol and heap memories.
// After the final item in_ready stays low while the sequencer heapifies, merges and walks.
// A sift-down level passes S_SDA, S_SDB and S_SDC and a sift-up level S_PU0 and S_PU1, as
// each memory read is registered; a set of n symbols needs n-1 merges.
// The walk holds while a result waits for ready.
// Reset is synchronous, active low, and clears only the control state.
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcb_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcb_pkg::out_item_t  out_data
);

  localparam int NODES = 2 * MAX_SYMBOLS - 1;
  localparam int NW    = $clog2(NODES + 1);
  localparam int SW    = $clog2(MAX_SYMBOLS);
  localparam int WW    = hcb_pkg::WEIGHT_W;

  // A heap slot carries its node's weight so that one read serves a comparison.
  typedef struct packed {
    logic [NW-1:0] node;
    logic [WW-1:0] wt;
  } heap_ent_t;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [5:0]    len;
    logic [62:0]   code;
  } stk_ent_t;

  localparam logic [4:0] S_LOAD = 5'd0;
  localparam logic [4:0] S_HB   = 5'd1;
  localparam logic [4:0] S_HB1  = 5'd2;
  localparam logic [4:0] S_SDA  = 5'd3;
  localparam logic [4:0] S_SDB  = 5'd4;
  localparam logic [4:0] S_SDC  = 5'd5;
  localparam logic [4:0] S_TM0  = 5'd6;
  localparam logic [4:0] S_TM1  = 5'd7;
  localparam logic [4:0] S_TM2  = 5'd8;
  localparam logic [4:0] S_MRG  = 5'd9;
  localparam logic [4:0] S_PU0  = 5'd10;
  localparam logic [4:0] S_PU1  = 5'd11;
  localparam logic [4:0] S_W0   = 5'd12;
  localparam logic [4:0] S_W1   = 5'd13;
  localparam logic [4:0] S_WP   = 5'd14;
  localparam logic [4:0] S_WR   = 5'd15;
  localparam logic [4:0] S_WL   = 5'd16;
  localparam logic [4:0] S_WL2  = 5'd17;
  localparam logic [4:0] S_WS   = 5'd18;
  localparam logic [4:0] S_WO   = 5'd19;

  logic [4:0]    st_r;
  logic [NW-1:0] cnt_r;       // symbol count
  logic          ovf_r;
  logic [NW-1:0] n_r;         // heap size
  logic [NW-1:0] next_r;
  logic [NW-1:0] i_r;         // bottom-up index
  logic [NW-1:0] pos_r;
  logic          second_r;
  logic          build_r;
  heap_ent_t     elem_r;      // entry being sifted down or inserted
  heap_ent_t     hl_r;
  heap_ent_t     ta_r;
  heap_ent_t     tb_r;
  logic [SW:0]   sp_r;
  logic [5:0]    wlen_r;
  logic [62:0]   wcode_r;
  logic [NW-1:0] lt_r;

  // Memories.
  logic          sym_we;
  logic [SW-1:0] sym_wa, sym_ra;
  logic [7:0]    sym_wd, sym_rd;
  logic          h_we;
  logic [SW-1:0] h_wa, h_ra;
  heap_ent_t     h_wd, h_rd;
  logic          lk_we;
  logic [NW-1:0] lk_wa, lk_ra;
  logic [2*NW-1:0] lk_wd, lk_rd;
  logic          k_we;
  logic [SW-1:0] k_wa, k_ra;
  stk_ent_t      k_wd, k_rd;

  hcb_ram #(.WIDTH(8), .DEPTH(MAX_SYMBOLS)) u_sym (
    .clk, .we(sym_we), .waddr(sym_wa), .wdata(sym_wd), .raddr(sym_ra), .rdata(sym_rd));
  hcb_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(MAX_SYMBOLS)) u_heap (
    .clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  hcb_ram #(.WIDTH(2 * NW), .DEPTH(NODES)) u_lnk (
    .clk, .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
  hcb_ram #(.WIDTH($bits(stk_ent_t)), .DEPTH(MAX_SYMBOLS)) u_stk (
    .clk, .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

  logic [NW:0]   lchild, rchild, n_ext;
  logic [NW-1:0] parent;
  assign lchild = {pos_r, 1'b1};
  assign rchild = {pos_r, 1'b0} + (NW+1)'(2);
  assign n_ext  = {1'b0, n_r};
  assign parent = (pos_r - NW'(1)) >> 1;

  logic          in_fits;
  logic [NW-1:0] cnt_inc, cnt_fin;
  assign in_fits = cnt_r < NW'(MAX_SYMBOLS);
  assign cnt_inc = cnt_r + NW'(1);
  assign cnt_fin = in_fits ? cnt_inc : cnt_r;

  logic out_valid_r;
  hcb_pkg::out_item_t out_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_ready  = (st_r == S_LOAD);

  // Smallest-child choice with strict comparisons; the left child is read before the right one.
  logic          l_win, r_win, up_c;
  logic [WW-1:0] bw_c;
  always_comb begin
    l_win = (lchild < n_ext) && (hl_r.wt < elem_r.wt);
    bw_c  = l_win ? hl_r.wt : elem_r.wt;
    r_win = (rchild < n_ext) && (h_rd.wt < bw_c);
    up_c  = h_rd.wt > elem_r.wt;
  end

  always_comb begin
    sym_we = 1'b0; sym_wa = cnt_r[SW-1:0]; sym_wd = in_data.symbol;
    sym_ra = k_rd.node[SW-1:0];
    h_we = 1'b0; h_wa = cnt_r[SW-1:0]; h_wd = {cnt_r, WW'(in_data.weight)}; h_ra = '0;
    lk_we = 1'b0; lk_wa = next_r; lk_wd = {ta_r.node, tb_r.node}; lk_ra = k_rd.node;
    k_we = 1'b0; k_wa = sp_r[SW-1:0];
    k_wd = {lk_rd[NW-1:0], 6'(wlen_r + 6'd1), {wcode_r[61:0], 1'b1}};
    k_ra = SW'(sp_r - (SW+1)'(1));
    unique case (st_r)
      S_LOAD: begin
        sym_we = in_valid && in_fits;
        h_we   = in_valid && in_fits;
      end
      S_HB: h_ra = SW'(i_r - NW'(1));
      S_SDA: h_ra = lchild[SW-1:0];
      S_SDB: h_ra = rchild[SW-1:0];
      S_SDC: begin
        h_we = 1'b1; h_wa = pos_r[SW-1:0];
        h_wd = r_win ? h_rd : (l_win ? hl_r : elem_r);
      end
      S_TM1: h_ra = SW'(n_r - NW'(1));
      S_MRG: lk_we = 1'b1;
      S_PU0: begin
        if (pos_r == '0) begin
          h_we = 1'b1; h_wa = '0; h_wd = elem_r;
        end else begin
          h_ra = parent[SW-1:0];
        end
      end
      S_PU1: begin
        h_we = 1'b1; h_wa = pos_r[SW-1:0]; h_wd = up_c ? h_rd : elem_r;
      end
      S_W1: begin k_we = 1'b1; k_wa = '0; k_wd = {h_rd.node, 6'd0, 63'd0}; end
      S_WL: k_we = 1'b1;
      S_WL2: begin
        k_we = 1'b1; k_wa = SW'(sp_r + (SW+1)'(1));
        k_wd = {lt_r, 6'(wlen_r + 6'd1), {wcode_r[61:0], 1'b0}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_LOAD: begin
          if (in_valid) begin
            if (in_fits) cnt_r <= cnt_inc;
            else ovf_r <= 1'b1;
            if (in_data.final_symbol) begin
              n_r <= cnt_fin; next_r <= cnt_fin; i_r <= cnt_fin >> 1;
              build_r <= 1'b1; st_r <= S_HB;
            end
          end
        end
        S_HB: begin
          if (i_r == '0) begin
            build_r <= 1'b0; second_r <= 1'b0;
            st_r <= (n_r > NW'(1)) ? S_TM0 : S_W0;
          end else begin
            i_r <= i_r - NW'(1); pos_r <= i_r - NW'(1); st_r <= S_HB1;
          end
        end
        S_HB1: begin elem_r <= h_rd; st_r <= S_SDA; end
        S_SDA: st_r <= S_SDB;
        S_SDB: begin hl_r <= h_rd; st_r <= S_SDC; end
        S_SDC: begin
          if (r_win) begin
            pos_r <= rchild[NW-1:0]; st_r <= S_SDA;
          end else if (l_win) begin
            pos_r <= lchild[NW-1:0]; st_r <= S_SDA;
          end else if (build_r) begin
            st_r <= S_HB;
          end else if (!second_r) begin
            second_r <= 1'b1; st_r <= S_TM0;
          end else begin
            st_r <= S_MRG;
          end
        end
        S_TM0: st_r <= S_TM1;
        S_TM1: begin
          if (second_r) tb_r <= h_rd;
          else ta_r <= h_rd;
          st_r <= S_TM2;
        end
        // The last slot fills the root and sinks in the shrunken heap.
        S_TM2: begin
          elem_r <= h_rd; n_r <= n_r - NW'(1); pos_r <= '0; st_r <= S_SDA;
        end
        S_MRG: begin
          elem_r <= {next_r, WW'(ta_r.wt + tb_r.wt)};
          pos_r <= n_r; n_r <= n_r + NW'(1); st_r <= S_PU0;
        end
        S_PU0: begin
          if (pos_r == '0) begin
            next_r <= next_r + NW'(1); second_r <= 1'b0;
            st_r <= (n_r > NW'(1)) ? S_TM0 : S_W0;
          end else begin
            st_r <= S_PU1;
          end
        end
        S_PU1: begin
          if (up_c) begin
            pos_r <= parent; st_r <= S_PU0;
          end else begin
            next_r <= next_r + NW'(1); second_r <= 1'b0;
            st_r <= (n_r > NW'(1)) ? S_TM0 : S_W0;
          end
        end
        S_W0: st_r <= S_W1;
        S_W1: begin sp_r <= (SW+1)'(1); st_r <= S_WP; end
        S_WP: begin
          if (sp_r == '0) begin
            cnt_r <= '0; ovf_r <= 1'b0; st_r <= S_LOAD;
          end else begin
            sp_r <= sp_r - (SW+1)'(1); st_r <= S_WR;
          end
        end
        S_WR: begin
          wlen_r <= k_rd.len; wcode_r <= k_rd.code;
          st_r <= (k_rd.node < cnt_r) ? S_WS : S_WL;
        end
        // The right child goes in first so that the left one is popped next.
        S_WL: begin lt_r <= lk_rd[2*NW-1:NW]; st_r <= S_WL2; end
        S_WL2: begin sp_r <= sp_r + (SW+1)'(2); st_r <= S_WP; end
        S_WS: begin
          out_r.code_symbol <= sym_rd;
          out_r.code_length <= wlen_r;
          out_r.code_bits   <= wcode_r;
          out_r.dropped     <= ovf_r;
          out_r.last_code   <= (sp_r == '0);
          out_valid_r <= 1'b1;
          st_r <= S_WO;
        end
        S_WO: begin
          if (out_ready) begin
            out_valid_r <= 1'b0; st_r <= S_WP;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int MAX_SYM = 64;
  localparam int NODE_CAP = 2 * MAX_SYM - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int WW = hcb_pkg::WEIGHT_W;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  hcb_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  hcb_pkg::out_item_t out_data;

  huffman_code_builder #(.MAX_SYMBOLS(MAX_SYM)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  hcb_pkg::in_item_t pending_symbols[$];
  hcb_pkg::out_item_t expected_codes[$];
  int mismatches = 0;
  int cycle_count = 0;

  // Shadow copy of the block's symbol store and tree.
  logic [7:0] leaf_sym[MAX_SYM];
  logic [WW-1:0] node_wt[NODE_CAP];
  int left_of[NODE_CAP];
  int right_of[NODE_CAP];
  int heap[MAX_SYM];
  int loaded_count = 0;
  bit overflowed = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic void sift_heap(input int pos, input int n);
    int l, r, best, t;
    forever begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      best = pos;
      if (l < n && node_wt[heap[l]] < node_wt[heap[best]]) best = l;
      if (r < n && node_wt[heap[r]] < node_wt[heap[best]]) best = r;
      if (best == pos) return;
      t = heap[pos];
      heap[pos] = heap[best];
      heap[best] = t;
      pos = best;
    end
  endfunction

  function automatic int pop_min(ref int n);
    int top;
    top = heap[0];
    n--;
    heap[0] = heap[n];
    sift_heap(0, n);
    return top;
  endfunction

  function automatic void build_codes();
    int n, next_node, i, sp, a, b, node, produced, idx;
    int stk_node[2 * MAX_SYM];
    int stk_len[2 * MAX_SYM];
    logic [63:0] stk_code[2 * MAX_SYM];
    int len;
    logic [63:0] code;
    hcb_pkg::out_item_t res;
    n = loaded_count;
    next_node = loaded_count;
    produced = 0;
    for (i = 0; i < loaded_count; i++) heap[i] = i;
    for (i = n / 2 - 1; i >= 0; i--) sift_heap(i, n);
    while (n > 1 && next_node < NODE_CAP) begin
      a = pop_min(n);
      b = pop_min(n);
      node_wt[next_node] = node_wt[a] + node_wt[b];
      left_of[next_node] = a;
      right_of[next_node] = b;
      // Insert the merged node, moving larger parents down.
      idx = n;
      n++;
      while (idx != 0 && node_wt[heap[(idx - 1) / 2]] > node_wt[next_node]) begin
        heap[idx] = heap[(idx - 1) / 2];
        idx = (idx - 1) / 2;
      end
      heap[idx] = next_node;
      next_node++;
    end
    stk_node[0] = heap[0];
    stk_len[0] = 0;
    stk_code[0] = '0;
    sp = 1;
    while (sp > 0 && produced < MAX_SYM) begin
      sp--;
      node = stk_node[sp];
      len = stk_len[sp];
      code = stk_code[sp];
      if (node < loaded_count) begin
        res.code_symbol = leaf_sym[node];
        res.code_length = len[5:0];
        res.code_bits = code[62:0];
        res.dropped = overflowed;
        res.last_code = 1'b0;
        expected_codes.push_back(res);
        produced++;
      end else if (sp + 2 <= 2 * MAX_SYM && len < 63) begin
        stk_node[sp] = right_of[node];
        stk_len[sp] = len + 1;
        stk_code[sp] = {code[62:0], 1'b1};
        sp++;
        stk_node[sp] = left_of[node];
        stk_len[sp] = len + 1;
        stk_code[sp] = {code[62:0], 1'b0};
        sp++;
      end
    end
    if (produced > 0) begin
      res = expected_codes.pop_back();
      res.last_code = 1'b1;
      expected_codes.push_back(res);
    end
  endfunction

  function automatic void predict_codes(input hcb_pkg::in_item_t item);
    if (loaded_count < MAX_SYM) begin
      leaf_sym[loaded_count] = item.symbol;
      node_wt[loaded_count] = WW'(item.weight);
      loaded_count++;
    end else begin
      overflowed = 1'b1;
    end
    if (item.final_symbol) begin
      if (loaded_count > 0) build_codes();
      loaded_count = 0;
      overflowed = 1'b0;
    end
  endfunction

  function automatic hcb_pkg::in_item_t make_symbol(input logic [7:0] sym,
                                                    input logic [23:0] wt, input logic fin);
    hcb_pkg::in_item_t it;
    it.symbol = sym;
    it.weight = wt;
    it.final_symbol = fin;
    return it;
  endfunction

  // Queues one symbol set; mode picks the weight spread, and modes 1 and 2 make ties occur often.
  task automatic queue_set(input int size, input int mode);
    logic [23:0] wt;
    for (int k = 0; k < size; k++) begin
      case (mode)
        0: wt = 24'($urandom);
        1: wt = 24'($urandom_range(0, 3));
        2: wt = 24'hFFFFFF - 24'($urandom_range(0, 2));
        default: wt = 24'($urandom_range(0, 1000));
      endcase
      pending_symbols.push_back(make_symbol(8'($urandom), wt, k == size - 1));
    end
  endtask

  initial begin
    int total;
    int set_idx;
    int size;
    // Lone symbols at both extremes.
    pending_symbols.push_back(make_symbol(8'h00, 24'h000000, 1'b1));
    pending_symbols.push_back(make_symbol(8'hFF, 24'hFFFFFF, 1'b1));
    // Two symbols, then equal weights, then a mix of extremes.
    pending_symbols.push_back(make_symbol(8'h55, 24'hFFFFFF, 1'b0));
    pending_symbols.push_back(make_symbol(8'hAA, 24'h000000, 1'b1));
    for (int k = 0; k < 5; k++)
      pending_symbols.push_back(make_symbol(8'(k + 1), 24'd7, k == 4));
    pending_symbols.push_back(make_symbol(8'h80, 24'hFFFFFF, 1'b0));
    pending_symbols.push_back(make_symbol(8'h01, 24'h000000, 1'b0));
    pending_symbols.push_back(make_symbol(8'h7F, 24'h800000, 1'b0));
    pending_symbols.push_back(make_symbol(8'hFE, 24'h000001, 1'b0));
    pending_symbols.push_back(make_symbol(8'h02, 24'h7FFFFF, 1'b0));
    pending_symbols.push_back(make_symbol(8'h40, 24'h000000, 1'b1));
    // Skewed weights give a deep, chain-like tree.
    for (int k = 0; k < 8; k++)
      pending_symbols.push_back(make_symbol(8'(16 + k), 24'(1 << (2 * k)), k == 7));

    total = pending_symbols.size();
    set_idx = 0;
    while (total < 300) begin
      if (set_idx == 3) size = 67;        // overflow, final item dropped
      else if (set_idx == 8) size = 64;   // exactly full
      else if ($urandom_range(0, 24) == 0) size = $urandom_range(30, 66);
      else size = $urandom_range(1, 12);
      queue_set(size, $urandom_range(0, 3));
      total += size;
      set_idx++;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_symbols.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_symbols.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall behavior changes mode every so often, including full speed.
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= cycle_count[2];
      endcase
    end
  end

  // Monitor: predicts on accepted input items and checks accepted results.
  always @(posedge clk) begin
    hcb_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_codes(in_data);
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected code for symbol %0h", out_data.code_symbol));
        end else begin
          want = expected_codes.pop_front();
          if (out_data.code_symbol !== want.code_symbol)
            report_mismatch($sformatf("code_symbol %0h, expected %0h",
                                      out_data.code_symbol, want.code_symbol));
          if (out_data.code_length !== want.code_length)
            report_mismatch($sformatf("code_length %0d, expected %0d",
                                      out_data.code_length, want.code_length));
          if (out_data.code_bits !== want.code_bits)
            report_mismatch($sformatf("code_bits %0h, expected %0h",
                                      out_data.code_bits, want.code_bits));
          if (out_data.dropped !== want.dropped)
            report_mismatch($sformatf("dropped %0b, expected %0b",
                                      out_data.dropped, want.dropped));
          if (out_data.last_code !== want.last_code)
            report_mismatch($sformatf("last_code %0b, expected %0b",
                                      out_data.last_code, want.last_code));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (pending_symbols.size() == 0 && !in_valid && expected_codes.size() == 0) break;
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/hcb_pkg.sv
rtl/core/hcb_ram.sv
rtl/core/huffman_code_builder.sv
test/testbench.sv
